// File: sv/wsd_pkg.sv
// Package for the WebSocket frame deframer: result kinds, reset constants and
// the queue entry type shared by the front end, the queue and the back end.
// No dependencies.
package wsd_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [31:0] MAX_LEN_RESET = 32'd268435456;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } wsd_entry_t;

endpackage

// File: sv/wsd_ifs.sv
// Valid/ready channel interfaces of the deframer: received bytes, results and
// the limit register write port. No dependencies.
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       final_fragment;
  logic       last_of_frame;
  modport source (output valid, output kind, output payload_byte, output frame_opcode,
                  output final_fragment, output last_of_frame, input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_opcode,
                  input final_fragment, input last_of_frame, output ready);
endinterface

interface wsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_payload_length;
  modport source (output valid, output max_payload_length, input ready);
  modport sink   (input valid, input max_payload_length, output ready);
endinterface

// File: sv/wsd_front.sv
// Deframer front end: parses header, length and key bytes and classifies each
// byte into a queue entry. Depends on wsd_pkg and wsd_ifs.
module wsd_front (
  input  logic               clk,
  input  logic               rst_n,
  wsd_byte_if.sink           in_ch,
  wsd_cfg_if.sink            cfg_ch,
  input  logic               q_full,
  output logic               q_push,
  output wsd_pkg::wsd_entry_t q_data
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HEAD0  = 3'd0;
  localparam logic [2:0] PH_HEAD1  = 3'd1;
  localparam logic [2:0] PH_EXTLEN = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_DEAD   = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [1:0]  keypos_r, keypos_nxt;
  logic [31:0] max_len_r;

  logic        in_acc;
  logic [7:0]  b;
  logic [63:0] len_shift;
  logic [63:0] len_cand;
  logic        too_long;
  logic        emit;
  logic [1:0]  e_kind;
  logic [7:0]  e_byte;
  logic [7:0]  e_key;
  logic        e_last;

  assign b           = in_ch.rx_byte;
  assign in_ch.ready = !q_full;
  assign in_acc      = in_ch.valid && !q_full;
  assign cfg_ch.ready = 1'b1;

  assign len_shift = {len_r[55:0], b};
  assign len_cand  = (phase_r == PH_HEAD1) ? {57'd0, b[6:0]} : len_shift;
  assign too_long  = (len_cand[63:32] != 32'd0) || (len_cand[31:0] > max_len_r);

  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    key_nxt    = key_r;
    remain_nxt = remain_r;
    keypos_nxt = keypos_r;
    emit       = 1'b0;
    e_kind     = KIND_PAYLOAD;
    e_byte     = 8'd0;
    e_key      = 8'd0;
    e_last     = 1'b0;
    case (phase_r)
      PH_HEAD1, PH_EXTLEN: begin
        if (phase_r == PH_HEAD1) begin
          masked_nxt = b[7];
          len_nxt    = 64'd0;
          left_nxt   = 4'd0;
        end else begin
          len_nxt  = len_shift;
          left_nxt = left_r - 4'd1;
        end
        if (phase_r == PH_HEAD1 && b[6:0] == 7'd126) begin
          left_nxt  = 4'd2;
          phase_nxt = PH_EXTLEN;
        end else if (phase_r == PH_HEAD1 && b[6:0] == 7'd127) begin
          left_nxt  = 4'd8;
          phase_nxt = PH_EXTLEN;
        end else if (phase_r == PH_HEAD1 || left_nxt == 4'd0) begin
          len_nxt = len_cand;
          if (too_long) begin
            phase_nxt = PH_DEAD;
            emit      = 1'b1;
            e_kind    = KIND_ERROR;
            e_last    = 1'b1;
          end else begin
            key_nxt = 32'd0;
            if (masked_nxt) begin
              left_nxt  = 4'd4;
              phase_nxt = PH_KEY;
            end else if (len_cand == 64'd0) begin
              phase_nxt = PH_HEAD0;
              emit      = 1'b1;
              e_kind    = KIND_EMPTY;
              e_last    = 1'b1;
            end else begin
              remain_nxt = len_cand[31:0];
              keypos_nxt = 2'd0;
              phase_nxt  = PH_DATA;
            end
          end
        end
      end
      PH_KEY: begin
        key_nxt  = {key_r[23:0], b};
        left_nxt = left_r - 4'd1;
        if (left_nxt == 4'd0) begin
          if (len_r == 64'd0) begin
            phase_nxt = PH_HEAD0;
            emit      = 1'b1;
            e_kind    = KIND_EMPTY;
            e_last    = 1'b1;
          end else begin
            remain_nxt = len_r[31:0];
            keypos_nxt = 2'd0;
            phase_nxt  = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        case (keypos_r)
          2'd0:    e_key = key_r[31:24];
          2'd1:    e_key = key_r[23:16];
          2'd2:    e_key = key_r[15:8];
          default: e_key = key_r[7:0];
        endcase
        keypos_nxt = keypos_r + 2'd1;
        remain_nxt = remain_r - 32'd1;
        emit       = 1'b1;
        e_kind     = KIND_PAYLOAD;
        e_byte     = b;
        e_last     = (remain_r == 32'd1);
        if (remain_r == 32'd1) begin
          phase_nxt = PH_HEAD0;
        end
      end
      PH_DEAD: begin
        phase_nxt = PH_DEAD;
      end
      default: begin
        fin_nxt    = b[7];
        opcode_nxt = b[3:0];
        phase_nxt  = PH_HEAD1;
      end
    endcase
  end

  assign q_push          = in_acc && emit;
  assign q_data.kind     = e_kind;
  assign q_data.raw_byte = e_byte;
  assign q_data.key_byte = e_key;
  assign q_data.opcode   = opcode_r;
  assign q_data.fin      = fin_r;
  assign q_data.last     = e_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEAD0;
      fin_r     <= 1'b0;
      opcode_r  <= 4'd0;
      masked_r  <= 1'b0;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      if (in_acc) begin
        phase_r  <= phase_nxt;
        fin_r    <= fin_nxt;
        opcode_r <= opcode_nxt;
        masked_r <= masked_nxt;
      end
      if (cfg_ch.valid) begin
        max_len_r <= cfg_ch.max_payload_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      key_r    <= key_nxt;
      remain_r <= remain_nxt;
      keypos_r <= keypos_nxt;
    end
  end

endmodule

// File: sv/wsd_queue.sv
// Short first-in first-out queue of classified entries between the front end
// and the back end. Depends on wsd_pkg.
module wsd_queue #(
  parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsd_pkg::wsd_entry_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output wsd_pkg::wsd_entry_t head
);
  import wsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsd_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/wsd_back.sv
// Deframer back end: unmasks queued entries and holds each result in an
// output register until it is taken. Depends on wsd_pkg and wsd_ifs.
module wsd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  wsd_pkg::wsd_entry_t q_head,
  output logic                q_pop,
  wsd_result_if.source        out_ch
);
  import wsd_pkg::*;

  logic       valid_r;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic [3:0] opcode_r;
  logic       fin_r;
  logic       last_r;

  assign q_pop = q_not_empty && (!valid_r || out_ch.ready);

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.payload_byte   = byte_r;
  assign out_ch.frame_opcode   = opcode_r;
  assign out_ch.final_fragment = fin_r;
  assign out_ch.last_of_frame  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= q_head.kind;
      byte_r   <= q_head.raw_byte ^ q_head.key_byte;
      opcode_r <= q_head.opcode;
      fin_r    <= q_head.fin;
      last_r   <= q_head.last;
    end
  end

endmodule

// File: sv/websocket_frame_deframer_top.sv
// WebSocket frame deframer top level: front end, entry queue and back end.
// A result passes through the entry queue and then the back end output register.
// Throughput: one byte per cycle unless stalled (front end single-byte parse step).
// The input stalls only when the entry queue is full behind a stalled output.
// Reset is synchronous: the parser awaits a first header byte and the limit is 2^28.
module websocket_frame_deframer_top #(
  parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  wsd_byte_if.sink     in_ch,
  wsd_cfg_if.sink      cfg_ch,
  wsd_result_if.source out_ch
);
  import wsd_pkg::*;

  wsd_entry_t push_data;
  wsd_entry_t head;
  logic       push;
  logic       pop;
  logic       full;
  logic       not_empty;

  wsd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  wsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .out_ch      (out_ch)
  );

endmodule

// File: bench/wsd_checker.sv
// Checker for the WebSocket frame deframer: watches the byte, limit and result
// channels, predicts every result and compares it field by field.
// Depends on wsd_pkg and the channel interfaces in wsd_ifs.sv.
module wsd_checker (
  input  logic        clk,
  input  logic        rst_n,
  wsd_byte_if         in_mon,
  wsd_cfg_if          cfg_mon,
  wsd_result_if       out_mon,
  output int unsigned fail_count,
  output int unsigned waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  typedef enum logic [2:0] {
    STG_FLAGS, STG_LENGTH, STG_EXTLEN, STG_KEY, STG_PAYLOAD, STG_HALTED
  } stage_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [31:0] limit;
  stage_t      stage;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] len_acc;
  logic [3:0]  hdr_left;
  logic [31:0] key;
  logic [31:0] remaining;
  logic [1:0]  key_pos;

  function automatic frame_result_t make_result(input logic [1:0] kind, input logic [7:0] data,
                                                input logic last);
    frame_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.opcode = opcode;
    r.fin    = fin;
    r.last   = last;
    return r;
  endfunction

  function automatic bit start_payload(output frame_result_t r);
    r = '0;
    if (len_acc == 64'd0) begin
      stage = STG_FLAGS;
      r = make_result(KIND_EMPTY, 8'd0, 1'b1);
      return 1'b1;
    end
    remaining = len_acc[31:0];
    key_pos = 2'd0;
    stage = STG_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit check_length(output frame_result_t r);
    r = '0;
    if (len_acc > {32'd0, limit}) begin
      stage = STG_HALTED;
      r = make_result(KIND_ERROR, 8'd0, 1'b1);
      return 1'b1;
    end
    key = 32'd0;
    if (masked) begin
      hdr_left = 4'd4;
      stage = STG_KEY;
      return 1'b0;
    end
    return start_payload(r);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
    logic [7:0] key_byte;
    r = '0;
    case (stage)
      STG_LENGTH: begin
        masked = b[7];
        len_acc = 64'd0;
        if (b[6:0] == 7'd126 || b[6:0] == 7'd127) begin
          hdr_left = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
          stage = STG_EXTLEN;
          return 1'b0;
        end
        len_acc = {57'd0, b[6:0]};
        return check_length(r);
      end
      STG_EXTLEN: begin
        len_acc = {len_acc[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 4'd0) return 1'b0;
        return check_length(r);
      end
      STG_KEY: begin
        key = {key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 4'd0) return 1'b0;
        return start_payload(r);
      end
      STG_PAYLOAD: begin
        key_byte = key[31 - 8 * key_pos -: 8];
        key_pos = key_pos + 2'd1;
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) stage = STG_FLAGS;
        r = make_result(KIND_PAYLOAD, b ^ key_byte, remaining == 32'd0);
        return 1'b1;
      end
      STG_HALTED: return 1'b0;
      default: begin
        fin = b[7];
        opcode = b[3:0];
        stage = STG_LENGTH;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at %0t: %s (got %0d, expected %0d)", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      limit     = MAX_LEN_RESET;
      stage     = STG_FLAGS;
      fin       = 1'b0;
      opcode    = 4'd0;
      masked    = 1'b0;
      len_acc   = 64'd0;
      hdr_left  = 4'd0;
      key       = 32'd0;
      remaining = 32'd0;
      key_pos   = 2'd0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.kind   = out_mon.kind;
        got.data   = out_mon.payload_byte;
        got.opcode = out_mon.frame_opcode;
        got.fin    = out_mon.final_fragment;
        got.last   = out_mon.last_of_frame;
        if (expected_results.size() == 0) begin
          report_mismatch("result with none expected, kind", got.kind, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
          if (got.data != want.data) report_mismatch("payload_byte", got.data, want.data);
          if (got.opcode != want.opcode)
            report_mismatch("frame_opcode", got.opcode, want.opcode);
          if (got.fin != want.fin) report_mismatch("final_fragment", got.fin, want.fin);
          if (got.last != want.last) report_mismatch("last_of_frame", got.last, want.last);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) limit = cfg_mon.max_payload_length;
      if (in_mon.valid && in_mon.ready) begin
        if (deframe_byte(in_mon.rx_byte, want))
          expected_results.insert(expected_results.size(), want);
      end
    end
    waiting = expected_results.size();
  end

endmodule

// File: bench/tb.sv
// Top of the deframer testbench: clock, reset, byte and limit stimulus, result
// back-pressure and the verdict. Depends on wsd_pkg, wsd_ifs.sv, wsd_checker
// and websocket_frame_deframer_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned waiting;
  int unsigned cycle_count;
  int unsigned bytes_pushed;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  bit          hold_req;
  bit          hold_taken;
  logic [7:0]  frame_bytes[$];
  int unsigned len_end;
  logic [31:0] last_limit;

  wsd_byte_if   in_ch ();
  wsd_cfg_if    cfg_ch ();
  wsd_result_if out_ch ();

  websocket_frame_deframer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  wsd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .cfg_mon    (cfg_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 79;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (bytes_pushed < 440) begin
      send_idle_pct = 31;
      recv_stall_pct = 72;
    end else if (bytes_pushed < 880) begin
      send_idle_pct = 72;
      recv_stall_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 1'b1;
    end
    bytes_pushed++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_payload_length <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic append_byte(input logic [7:0] v);
    frame_bytes.insert(frame_bytes.size(), v);
  endtask

  // Appends the length field: seven-bit, 16-bit or 64-bit big-endian form.
  task automatic put_length(input logic masked, input int unsigned form, input logic [63:0] len);
    int i;
    if (form == 0) begin
      append_byte({masked, len[6:0]});
    end else if (form == 1) begin
      append_byte({masked, 7'd126});
      append_byte(len[15:8]);
      append_byte(len[7:0]);
    end else begin
      append_byte({masked, 7'd127});
      for (i = 7; i >= 0; i--) append_byte(len[8 * i +: 8]);
    end
    len_end = frame_bytes.size();
  endtask

  task automatic build_frame(input logic [31:0] limit);
    int unsigned sel;
    int unsigned cap;
    int unsigned len;
    int unsigned form;
    logic        masked;
    int unsigned i;
    frame_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 8) cap = 0;
    else if (sel < 80) cap = 12;
    else if (sel < 96) cap = 60;
    else cap = 300;
    if (cap > limit) cap = limit;
    len = $urandom_range(0, cap);
    sel = $urandom_range(0, 9);
    form = (len > 125 || sel >= 6) ? 1 + (sel % 2) : 0;
    masked = 1'($urandom_range(0, 1));
    append_byte(8'($urandom()));
    put_length(masked, form, 64'(len));
    if (masked) for (i = 0; i < 4; i++) append_byte(8'($urandom()));
    for (i = 0; i < len; i++) append_byte(8'($urandom()));
  endtask

  // A frame whose length exceeds the limit, followed by bytes that must be dropped.
  task automatic build_oversize();
    int unsigned variant;
    logic [63:0] len;
    logic [31:0] upper;
    int unsigned i;
    frame_bytes.delete();
    variant = $urandom_range(0, 3);
    append_byte(8'($urandom()));
    case (variant)
      0: begin
        last_limit = $urandom_range(0, 124);
        len = 64'($urandom_range(last_limit + 1, 125));
        put_length(1'($urandom_range(0, 1)), 0, len);
      end
      1: begin
        last_limit = $urandom_range(0, 65534);
        len = 64'($urandom_range(last_limit + 1, 65535));
        put_length(1'($urandom_range(0, 1)), 1, len);
      end
      2: begin
        last_limit = $urandom();
        len = {$urandom() | 32'h8000_0000, $urandom()};
        put_length(1'($urandom_range(0, 1)), 2, len);
      end
      default: begin
        last_limit = 32'hFFFF_FFFF;
        upper = $urandom();
        if (upper == 32'd0) upper = 32'd1;
        len = {upper, $urandom()};
        put_length(1'($urandom_range(0, 1)), 2, len);
      end
    endcase
    for (i = 0; i < 20; i++) append_byte(8'($urandom()));
  endtask

  // Sends the frame in frame_bytes, writing the new limit part-way through its header.
  task automatic send_with_limit(input logic [31:0] limit);
    int unsigned split;
    int unsigned i;
    split = $urandom_range(1, len_end - 1);
    for (i = 0; i < split; i++) push_byte(frame_bytes[i]);
    drain();
    set_limit(limit);
    for (i = split; i < frame_bytes.size(); i++) push_byte(frame_bytes[i]);
  endtask

  task automatic run_phase(input logic [31:0] limit, input int unsigned budget);
    int unsigned sent;
    build_frame(limit);
    send_with_limit(limit);
    sent = frame_bytes.size();
    while (sent < budget) begin
      build_frame(limit);
      foreach (frame_bytes[i]) push_byte(frame_bytes[i]);
      sent += frame_bytes.size();
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_payload_length = 32'd0;
    directed = '{8'h81, 8'h00,
                 8'h8A, 8'h80, 8'h00, 8'hFF, 8'h00, 8'hFF,
                 8'h09, 8'h7E, 8'h00, 8'h00,
                 8'hF3, 8'h81, 8'hA5, 8'h00, 8'h00, 8'h00, 8'hFF,
                 8'h00, 8'h02, 8'h00, 8'hFF};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) push_byte(directed[i]);
    run_phase(32'd0, 60);
    run_phase(32'hFFFF_FFFF, 400);
    run_phase(32'd3, 150);
    run_phase($urandom_range(100, 400), 350);
    run_phase($urandom(), 340);
    build_oversize();
    send_with_limit(last_limit);
    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: websocket_frame_deframer_top.f
sv/wsd_pkg.sv
sv/wsd_ifs.sv
sv/wsd_front.sv
sv/wsd_queue.sv
sv/wsd_back.sv
sv/websocket_frame_deframer_top.sv
bench/wsd_checker.sv
bench/tb.sv
